### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check runs on the rising edge of clk
// and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// A condition that implies a consequence in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wto_pkg.sv
package wto_pkg;

	// Operation codes carried in tuser.
	localparam logic [1:0] OP_WRITE_X = 2'd0;
	localparam logic [1:0] OP_WRITE_Y = 2'd1;
	localparam logic [1:0] OP_SAMPLE  = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] REG_X_LENGTH = 1'b0;
	localparam logic [0:0] REG_Y_LENGTH = 1'b1;

	// Field widths.
	localparam int LEN_W     = 13;
	localparam int VAL_W     = 16;
	localparam int AMP_W     = 24;
	localparam int COORD_W   = 24;
	localparam int PHASE_W   = 32;
	localparam int SAMPLE_W  = 32;
	localparam int SIN_MAG_W = 15;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

	// Quarter turn in radians, Q30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [VAL_W-1:0] entry_t;

	// Denominators of the sine series terms, (2n)(2n+1).
	function automatic logic [7:0] taylor_denom(input int n);
		logic [7:0] d;
		case (n)
			1: d = 8'd6;
			2: d = 8'd20;
			3: d = 8'd42;
			4: d = 8'd72;
			5: d = 8'd110;
			6: d = 8'd156;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

endpackage

### rtl/wave_terrain_oscillator_unit.sv
// Table write beats give no result and leave the unit ready for the next beat.
// A sample beat gives its result in the output register, and the next beat is taken only once that
// result is written, which waits while the output register is full: the sine ROM read, the scan
// multipliers, the table read port and the two product stages are passed one at a time.
// Reset clears the orbit phase, sets both lengths to 4096 and empties the output register;
// the wave tables are undefined until written and get no clearing pass.
`include "assert_macros.svh"

module wave_terrain_oscillator_unit #(
	parameter int TABLE_DEPTH    = 4096,
	parameter int SINE_ROM_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// entry_index, entry_value, amplitude, phase_step, center_x, center_y,
	// radius_x, radius_y, then zero fill
	input  logic [183:0]              s_tdata,
	// op
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// sample
	output logic [31:0]               m_tdata,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [wto_pkg::LEN_W-1:0] cfg_data
);
	import wto_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int RAW = $clog2(SINE_ROM_DEPTH + 1);
	localparam int SPW = 30 + RAW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_ROM   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_INDEX = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_AMP   = 3'd6;

	// Input fields.
	logic [11:0]                in_entry_index;
	entry_t                     in_entry_value;
	logic signed [AMP_W-1:0]    in_amplitude;
	logic [PHASE_W-1:0]         in_phase_step;
	logic signed [COORD_W-1:0]  in_center_x;
	logic signed [COORD_W-1:0]  in_center_y;
	logic signed [COORD_W-1:0]  in_radius_x;
	logic signed [COORD_W-1:0]  in_radius_y;

	assign in_entry_index = s_tdata[11:0];
	assign in_entry_value = s_tdata[27:12];
	assign in_amplitude   = s_tdata[51:28];
	assign in_phase_step  = s_tdata[83:52];
	assign in_center_x    = s_tdata[107:84];
	assign in_center_y    = s_tdata[131:108];
	assign in_radius_x    = s_tdata[155:132];
	assign in_radius_y    = s_tdata[179:156];

	logic [2:0]                state_q;
	logic                      in_accept;
	logic                      out_valid_q;
	logic [SAMPLE_W-1:0]       out_data_q;
	logic                      out_free;
	logic [PHASE_W-1:0]        phase_q;
	logic [LEN_W-1:0]          x_len_q;
	logic [LEN_W-1:0]          y_len_q;

	logic signed [AMP_W-1:0]   amp_q;
	logic [PHASE_W-1:0]        step_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic signed [COORD_W-1:0] rx_q;
	logic signed [COORD_W-1:0] ry_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_len_q <= LEN_RESET;
			y_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LENGTH: x_len_q <= cfg_data;
				REG_Y_LENGTH: y_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample parameters are held for the whole pass.
	always_ff @(posedge clk) begin
		if (in_accept && s_tuser == OP_SAMPLE) begin
			amp_q  <= in_amplitude;
			step_q <= in_phase_step;
			cx_q   <= in_center_x;
			cy_q   <= in_center_y;
			rx_q   <= in_radius_x;
			ry_q   <= in_radius_y;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && s_tuser == OP_SAMPLE) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR:  state_q <= ST_ROM;
				ST_ROM:   state_q <= ST_SCAN;
				ST_SCAN:  state_q <= ST_INDEX;
				ST_INDEX: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_AMP;
				ST_AMP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Quadrant index. Cosine is a quarter turn ahead, so it shares the index
	// and mirrors the opposite way.
	logic [SPW-1:0] rom_scale;
	logic [RAW-1:0] quad_idx;
	logic [RAW-1:0] quad_mirror;
	logic [1:0]     sin_quad;
	logic [1:0]     cos_quad;

	assign rom_scale   = SPW'(phase_q[29:0]) * SPW'(SINE_ROM_DEPTH);
	assign quad_idx    = rom_scale[SPW-1 -: RAW];
	assign quad_mirror = RAW'(SINE_ROM_DEPTH) - quad_idx;
	assign sin_quad    = phase_q[31:30];
	assign cos_quad    = sin_quad + 2'd1;

	logic [RAW-1:0]       sin_addr_s1;
	logic [RAW-1:0]       cos_addr_s1;
	logic                 sin_neg_s1;
	logic                 cos_neg_s1;
	logic [SIN_MAG_W-1:0] sin_mag;
	logic [SIN_MAG_W-1:0] cos_mag;

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			sin_addr_s1 <= sin_quad[0] ? quad_mirror : quad_idx;
			cos_addr_s1 <= sin_quad[0] ? quad_idx : quad_mirror;
			sin_neg_s1  <= sin_quad[1];
			cos_neg_s1  <= cos_quad[1];
		end
	end

	// The phase used by a sample is the one before its advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (state_q == ST_ADDR) begin
			phase_q <= phase_q + step_q;
		end
	end

	wto_sine_rom #(
		.DEPTH(SINE_ROM_DEPTH)
	) u_sine_rom (
		.clk   (clk),
		.addr_a(sin_addr_s1),
		.addr_b(cos_addr_s1),
		.data_a(sin_mag),
		.data_b(cos_mag)
	);

	// Scan point fraction: center plus radius times sine (x) or cosine (y), low 16 bits only.
	logic signed [VAL_W-1:0]         sin_val;
	logic signed [VAL_W-1:0]         cos_val;
	logic signed [COORD_W+VAL_W-1:0] prod_x;
	logic signed [COORD_W+VAL_W-1:0] prod_y;
	logic [15:0]                     frac_x_s2;
	logic [15:0]                     frac_y_s2;

	assign sin_val = sin_neg_s1 ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
	assign cos_val = cos_neg_s1 ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
	assign prod_x  = rx_q * sin_val;
	assign prod_y  = ry_q * cos_val;

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			frac_x_s2 <= cx_q[15:0] + prod_x[30:15];
			frac_y_s2 <= cy_q[15:0] + prod_y[30:15];
		end
	end

	// Table index: fraction scaled by the length in use.
	logic [LEN_W-1:0] x_eff;
	logic [LEN_W-1:0] y_eff;
	logic [31:0]      x_scale;
	logic [31:0]      y_scale;
	logic [AW-1:0]    x_addr;
	logic [AW-1:0]    y_addr;

	assign x_eff   = (32'(x_len_q) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : x_len_q;
	assign y_eff   = (32'(y_len_q) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : y_len_q;
	assign x_scale = 32'(frac_x_s2) * 32'(x_eff);
	assign y_scale = 32'(frac_y_s2) * 32'(y_eff);
	assign x_addr  = x_scale[16 +: AW];
	assign y_addr  = y_scale[16 +: AW];

	// Wave tables: one write port from the input beat, one registered read.
	entry_t x_mem [0:TABLE_DEPTH-1];
	entry_t y_mem [0:TABLE_DEPTH-1];
	entry_t x_rd_s3;
	entry_t y_rd_s3;
	logic   write_in_range;

	assign write_in_range = 32'(in_entry_index) < 32'(TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (in_accept && s_tuser == OP_WRITE_X && write_in_range) begin
			x_mem[AW'(in_entry_index)] <= in_entry_value;
		end
		if (state_q == ST_INDEX) begin
			x_rd_s3 <= x_mem[x_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && s_tuser == OP_WRITE_Y && write_in_range) begin
			y_mem[AW'(in_entry_index)] <= in_entry_value;
		end
		if (state_q == ST_INDEX) begin
			y_rd_s3 <= y_mem[y_addr];
		end
	end

	// Products: entries first, then the gain, floored by 2^30.
	logic signed [2*VAL_W-1:0]       xy_s4;
	logic signed [2*VAL_W+AMP_W-1:0] amp_prod;

	assign amp_prod = xy_s4 * amp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			xy_s4 <= x_rd_s3 * y_rd_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AMP && out_free) begin
			out_data_q <= {{6{amp_prod[55]}}, amp_prod[55:30]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_AMP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	`ASSERT_NEXT(a_sample_starts, in_accept && s_tuser == OP_SAMPLE, state_q == ST_ADDR, "sample beat did not start a pass")
	`ASSERT_NEXT(a_write_stays_idle, in_accept && s_tuser != OP_SAMPLE, state_q == ST_IDLE, "table write left the idle state")
	`ASSERT_NEXT(a_phase_holds, state_q != ST_ADDR, $stable(phase_q), "orbit phase moved outside its advance")
	`ASSERT_NEXT(a_result_waits, state_q == ST_AMP && out_valid_q && !m_tready, state_q == ST_AMP, "result dropped while output register was full")
	`ASSERT_SAME(a_rom_addr_range, state_q == ST_ROM, 32'(sin_addr_s1) <= SINE_ROM_DEPTH && 32'(cos_addr_s1) <= SINE_ROM_DEPTH, "sine ROM address beyond last entry")

endmodule

### rtl/wto_sine_rom.sv
module wto_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic [$clog2(DEPTH+1)-1:0]     addr_a,
	input  logic [$clog2(DEPTH+1)-1:0]     addr_b,
	output logic [wto_pkg::SIN_MAG_W-1:0]  data_a,
	output logic [wto_pkg::SIN_MAG_W-1:0]  data_b
);
	import wto_pkg::*;

	typedef logic [SIN_MAG_W-1:0] rom_t [0:DEPTH];

	// Quarter sine in Q0.15, evaluated in Q30 by a series up to x^13.
	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		for (int k = 0; k <= DEPTH; k++) begin
			x = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			for (int n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / 64'(taylor_denom(n));
				if (n[0]) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = 64'sd0;
			end
			sum = (sum + 64'sd16384) >>> 15;
			if (sum > 64'sd32767) begin
				sum = 64'sd32767;
			end
			r[k] = sum[SIN_MAG_W-1:0];
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	// Two registered read ports, one for sine and one for cosine.
	always_ff @(posedge clk) begin
		data_a <= ROM[addr_a];
		data_b <= ROM[addr_b];
	end

endmodule
